[src/jfce_pkg.sv]
// Package: shared constants, payload types and control types for the frame extractor.
`timescale 1ns / 1ps
package jfce_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = ADDR_W + 1;
  localparam int HDR_BYTES   = 4;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  typedef struct packed {
    logic       vsync;
    logic       href;
    logic [7:0] pixel_byte;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CAPTURE,
    PH_DRAIN,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic arm;
    logic store;
    logic drain_start;
    logic drain_step;
  } dp_cmd_t;

  typedef struct packed {
    logic count_nz;
    logic end_found;
    logic drain_last;
  } dp_sts_t;

endpackage

[src/jfce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module jfce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/jfce_ctrl.sv]
// Controller: phase state machine, vsync edge detection and the one_shot register.
`timescale 1ns / 1ps
module jfce_ctrl import jfce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  pixel_t  pixel,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  phase_t phase;
  phase_t phase_next;
  phase_t done_phase;
  logic   prev_vsync;
  logic   one_shot;
  logic   accept;
  logic   rise;
  logic   fall;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign rise       = accept && pixel.vsync && !prev_vsync;
  assign fall       = accept && !pixel.vsync && prev_vsync;
  assign done_phase = one_shot ? PH_HALT : PH_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      prev_vsync <= 1'b0;
      one_shot   <= 1'b1;
    end else begin
      phase <= phase_next;
      if (accept) begin
        prev_vsync <= pixel.vsync;
      end
      if (cfg_we) begin
        one_shot <= cfg_wdata;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (rise) begin
          phase_next = PH_CAPTURE;
        end
      end
      PH_CAPTURE: begin
        if (rise) begin
          phase_next = PH_CAPTURE;
        end else if (fall && sts.count_nz) begin
          phase_next = sts.end_found ? PH_DRAIN : done_phase;
        end
      end
      PH_DRAIN: begin
        if (accept && sts.drain_last) begin
          phase_next = done_phase;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (phase)
      PH_IDLE: begin
        cmd.arm = rise;
      end
      PH_CAPTURE: begin
        cmd.arm         = rise;
        cmd.store       = accept && !rise && !fall && pixel.href;
        cmd.drain_start = fall && sts.count_nz && sts.end_found;
      end
      PH_DRAIN: begin
        cmd.drain_step = accept;
      end
      PH_HALT: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[src/jfce_dp.sv]
// Datapath: frame store, marker tracking, length header and drain output registers.
`timescale 1ns / 1ps
module jfce_dp import jfce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] pixel_byte,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       result_strobe,
  output result_t    result
);

  logic [CNT_W-1:0]  byte_count;
  logic [ADDR_W-1:0] start_pos;
  logic [ADDR_W-1:0] end_pos;
  logic              end_found;
  logic              prev_was_ff;
  logic [IDX_W-1:0]  send_index;

  logic              out_valid;
  logic              out_from_ram;
  logic              out_last;
  logic [7:0]        hdr_byte;
  logic [7:0]        ram_rdata;

  logic              store_ok;
  logic              marker_ok;
  logic [IDX_W-1:0]  frame_len;
  logic [IDX_W-1:0]  len_plus_hdr;
  logic              in_header;
  logic [IDX_W-1:0]  body_off;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0]        hdr_sel;
  logic [31:0]       len_word;
  logic [7:0]        hdr_byte_next;
  logic              last_next;

  assign store_ok     = cmd.store && !byte_count[CNT_W-1];
  assign marker_ok    = prev_was_ff && !end_found && (byte_count != '0);
  assign frame_len    = {1'b0, end_pos} - {1'b0, start_pos} + IDX_W'(1);
  assign len_plus_hdr = frame_len + IDX_W'(HDR_BYTES);
  assign in_header    = send_index < IDX_W'(HDR_BYTES);
  assign body_off     = send_index - IDX_W'(HDR_BYTES);
  assign rd_addr      = start_pos + body_off[ADDR_W-1:0];
  assign hdr_sel      = 2'(HDR_BYTES - 1) - send_index[1:0];
  assign len_word     = 32'(frame_len);
  assign hdr_byte_next = 8'(len_word >> {hdr_sel, 3'b000});
  assign last_next    = (send_index + IDX_W'(1)) == len_plus_hdr;

  assign sts.count_nz   = byte_count != '0;
  assign sts.end_found  = end_found;
  assign sts.drain_last = last_next;

  jfce_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_ok),
    .waddr (byte_count[ADDR_W-1:0]),
    .wdata (pixel_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      start_pos   <= '0;
      end_pos     <= '0;
      end_found   <= 1'b0;
      prev_was_ff <= 1'b0;
      send_index  <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= cmd.drain_step;
      if (cmd.arm) begin
        byte_count  <= '0;
        start_pos   <= '0;
        end_pos     <= '0;
        end_found   <= 1'b0;
        prev_was_ff <= 1'b0;
      end else if (store_ok) begin
        if (marker_ok && pixel_byte == MARK_SOI) begin
          start_pos <= byte_count[ADDR_W-1:0] - ADDR_W'(1);
        end else if (marker_ok && pixel_byte == MARK_EOI) begin
          end_pos   <= byte_count[ADDR_W-1:0];
          end_found <= 1'b1;
        end
        prev_was_ff <= pixel_byte == MARK_FF;
        byte_count  <= byte_count + CNT_W'(1);
      end
      if (cmd.drain_start) begin
        send_index <= '0;
      end else if (cmd.drain_step) begin
        send_index <= send_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_step) begin
      hdr_byte     <= hdr_byte_next;
      out_from_ram <= !in_header;
      out_last     <= last_next;
    end
  end

  assign result_strobe    = out_valid;
  assign result.out_byte  = out_from_ram ? ram_rdata : hdr_byte;
  assign result.last_byte = out_last;

  a_no_store_in_drain: assert property (@(posedge clk) disable iff (rst)
    !(cmd.store && cmd.drain_step))
    else $error("store and drain in the same cycle");

  a_strobe_follows_step: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |=> result_strobe)
    else $error("drained item produced no result");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |-> send_index < len_plus_hdr)
    else $error("drain index past end of frame");

  a_markers_ordered: assert property (@(posedge clk) disable iff (rst)
    end_found |-> start_pos < end_pos)
    else $error("frame start not before frame end");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(STORE_DEPTH))
    else $error("byte count beyond store depth");

endmodule

[src/jpeg_frame_capture_extract.sv]
// Top level: JPEG frame capture from a camera byte stream and length-prefixed extraction.
//
//  Channel  | Ports                          | Handshake
//  ---------+--------------------------------+-----------------------------------------
//  item in  | start, busy, pixel             | taken on a clock edge with start & !busy
//  result   | result_strobe, result          | one cycle per result, no back-pressure
//  config   | cfg_we, cfg_wdata (one_shot)   | written on a clock edge with cfg_we
//
// One item is taken every cycle; busy stays low. A result appears the cycle after
// the item that causes it, set by the registered read of the frame store.
// Capture writes one store entry per item that has href set while the store has room; drain emits one byte per item.
// Synchronous reset returns to idle with one_shot = 1; the frame store is not cleared.
// The result side cannot stall.
`timescale 1ns / 1ps
module jpeg_frame_capture_extract import jfce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  pixel_t  pixel,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  output logic    result_strobe,
  output result_t result
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  jfce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pixel     (pixel),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  jfce_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .pixel_byte    (pixel.pixel_byte),
    .cmd           (cmd),
    .sts           (sts),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

[sim/jpeg_frame_capture_extract_tb.sv]
// Testbench for the JPEG frame extractor: directed and random camera frames checked against a predictor.
`timescale 1ns / 1ps
module jpeg_frame_capture_extract_tb;
  import jfce_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  class extract_scoreboard;
    logic [7:0]       store_mem [STORE_DEPTH];
    logic [CNT_W-1:0] fill_cnt;
    logic [ADDR_W-1:0] soi_pos;
    logic [ADDR_W-1:0] eoi_pos;
    logic [IDX_W-1:0] sent;
    logic             eoi_seen;
    logic             last_ff;
    logic             vs_q;
    logic             one_shot;
    phase_t           ph;
    result_t          expected_bytes[$];
    int               errors;
    int               checked;
    int               frames_out;

    function new();
      fill_cnt = '0;
      soi_pos = '0;
      eoi_pos = '0;
      sent = '0;
      eoi_seen = 1'b0;
      last_ff = 1'b0;
      vs_q = 1'b0;
      one_shot = 1'b1;
      ph = PH_IDLE;
      errors = 0;
      checked = 0;
      frames_out = 0;
    endfunction

    task report(string what);
      if (errors < 40) $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    function void arm();
      fill_cnt = '0;
      soi_pos = '0;
      eoi_pos = '0;
      eoi_seen = 1'b0;
      last_ff = 1'b0;
      ph = PH_CAPTURE;
    endfunction

    function void frame_end();
      ph = one_shot ? PH_HALT : PH_IDLE;
    endfunction

    function void note_config(logic v);
      one_shot = v;
    endfunction

    // Advance the frame state by one accepted pixel; return 1 if the item was not ignored.
    function bit note_pixel(pixel_t p);
      logic rise;
      logic fall;
      bit live;
      logic [CNT_W-1:0] len;
      int sh;
      result_t r;
      rise = p.vsync && !vs_q;
      fall = !p.vsync && vs_q;
      vs_q = p.vsync;
      live = (ph == PH_CAPTURE) || (ph == PH_DRAIN) || (ph == PH_IDLE && rise);
      case (ph)
        PH_IDLE: begin
          if (rise) arm();
        end
        PH_CAPTURE: begin
          if (rise) begin
            arm();
          end else if (fall) begin
            if (fill_cnt != 0) begin
              if (eoi_seen) begin
                ph = PH_DRAIN;
                sent = '0;
              end else begin
                frame_end();
              end
            end
          end else if (p.href && fill_cnt < STORE_DEPTH) begin
            store_mem[ADDR_W'(fill_cnt)] = p.pixel_byte;
            if (last_ff && !eoi_seen && fill_cnt > 0) begin
              if (p.pixel_byte == MARK_SOI) begin
                soi_pos = ADDR_W'(fill_cnt - 1'b1);
              end else if (p.pixel_byte == MARK_EOI) begin
                eoi_pos = ADDR_W'(fill_cnt);
                eoi_seen = 1'b1;
              end
            end
            last_ff = (p.pixel_byte == MARK_FF);
            fill_cnt = fill_cnt + 1'b1;
          end
        end
        PH_DRAIN: begin
          len = {1'b0, eoi_pos} - {1'b0, soi_pos} + 1'b1;
          if (sent < HDR_BYTES) begin
            sh = 8 * (HDR_BYTES - 1 - int'(sent));
            r.out_byte = 8'(32'(len) >> sh);
          end else begin
            r.out_byte = store_mem[ADDR_W'(int'(soi_pos) + int'(sent) - HDR_BYTES)];
          end
          r.last_byte = (int'(sent) + 1 == int'(len) + HDR_BYTES);
          sent = sent + 1'b1;
          if (r.last_byte) frame_end();
          expected_bytes.push_back(r);
        end
        default: ;
      endcase
      return live;
    endfunction

    task check_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.last_byte !== want.last_byte)
          report($sformatf("last_byte %0b, want %0b (byte %02h)", got.last_byte,
                           want.last_byte, want.out_byte));
        if (want.last_byte) frames_out++;
        checked++;
      end
    endtask

    task flush_check();
      if (expected_bytes.size() != 0)
        report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit draining();
      return ph == PH_DRAIN;
    endfunction

    function bit vsync_high();
      return vs_q;
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  pixel_t  pixel;
  logic    cfg_we;
  logic    cfg_wdata;
  logic    result_strobe;
  result_t result;

  extract_scoreboard sb = new();
  bit burst;
  int n_live;

  jpeg_frame_capture_extract u_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .pixel,
    .cfg_we,
    .cfg_wdata,
    .result_strobe,
    .result
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_byte(result);
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic put_item(logic v, logic h, logic [7:0] b);
    int gap;
    pixel_t p;
    gap = pick_gap();
    p.vsync = v;
    p.href = h;
    p.pixel_byte = b;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    if (sb.note_pixel(p)) n_live++;
  endtask

  task automatic put_noise();
    put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  // Drop vsync and finish any drain so the next item can start a fresh frame.
  task automatic settle();
    while (sb.draining() || sb.vsync_high()) put_item(1'b0, 1'($urandom_range(0, 1)),
                                                      8'($urandom));
  endtask

  task automatic capture(octet_q_t data);
    put_item(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? MARK_FF : 8'($urandom));
    foreach (data[i]) begin
      while (!burst && $urandom_range(0, 9) == 0) put_item(1'b1, 1'b0, 8'($urandom));
      put_item(1'b1, 1'b1, data[i]);
    end
    put_item(1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
    while (sb.draining()) put_noise();
    settle();
  endtask

  task automatic set_one_shot(logic v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.note_config(v);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    octet_q_t q;
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 24);
    repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
    if ($urandom_range(0, 9) < 8) begin
      q.push_back(MARK_FF);
      q.push_back(MARK_SOI);
    end
    repeat (n) q.push_back(($urandom_range(0, 9) == 0) ? MARK_FF : 8'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      q.push_back(MARK_FF);
      q.push_back(MARK_SOI);
      repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 19) != 0) begin
      q.push_back(MARK_FF);
      q.push_back(MARK_EOI);
    end
    repeat ($urandom_range(0, 3)) begin
      q.push_back(MARK_FF);
      q.push_back($urandom_range(0, 1) ? MARK_SOI : MARK_EOI);
    end
    burst = ($urandom_range(0, 3) == 0);
    capture(q);
    burst = 1'b0;
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12)) put_noise();
    while (sb.draining()) put_noise();
    settle();
  endtask

  initial begin
    octet_q_t q;
    int target;
    rst <= 1'b1;
    start <= 1'b0;
    pixel <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    burst = 1'b0;
    n_live = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_one_shot(1'b0);

    // zero-count fall keeps capture armed; the next rise clears the byte count and the FF state
    put_item(1'b1, 1'b0, 8'h00);
    put_item(1'b0, 1'b1, MARK_FF);
    put_item(1'b0, 1'b1, MARK_FF);
    q = '{MARK_EOI, 8'h12, MARK_FF, MARK_EOI};
    capture(q);
    q = '{8'h11, 8'h22, MARK_FF, MARK_EOI, 8'h33};
    capture(q);
    q = '{MARK_FF, MARK_EOI};
    capture(q);
    q = '{MARK_FF, MARK_SOI, MARK_FF, MARK_EOI};
    capture(q);
    q = '{MARK_SOI, MARK_FF, MARK_EOI};
    capture(q);
    q = '{8'h00, MARK_FF, MARK_SOI, 8'h7F, MARK_FF, MARK_FF, MARK_SOI, 8'h80, MARK_FF,
          MARK_EOI, MARK_FF, MARK_SOI, MARK_FF, MARK_EOI};
    capture(q);
    q = '{MARK_FF, MARK_SOI, 8'h00, MARK_FF, 8'h55, 8'hAA, MARK_FF, 8'h00, MARK_FF, MARK_EOI};
    capture(q);
    q = '{MARK_FF, MARK_SOI, 8'h01, 8'h02};
    capture(q);

    target = n_live + 1800;
    while (n_live < target) begin
      if ($urandom_range(0, 6) == 0) noise_burst();
      else random_frame();
    end

    // one_shot halts after the first frame; clearing it later must not resume
    q = '{8'h00, MARK_FF, MARK_SOI, 8'h3C, 8'hC3, MARK_FF, MARK_EOI};
    set_one_shot(1'b1);
    capture(q);
    capture(q);
    set_one_shot(1'b0);
    capture(q);

    start <= 1'b0;
    for (int w = 0; w < 100 && sb.pending() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.flush_check();
    $display("Run: %0d live items, %0d bytes checked, %0d frames extracted.",
             n_live, sb.checked, sb.frames_out);
    $display("Covered marker corner cases, zero-count falls, rearm and one-shot halt.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[files.f]
src/jfce_pkg.sv
src/jfce_ram.sv
src/jfce_ctrl.sv
src/jfce_dp.sv
src/jpeg_frame_capture_extract.sv
sim/jpeg_frame_capture_extract_tb.sv
